// ===== hw/rtl/fra_pkg.sv =====
// shared types, constants and helpers for the fra par rate accumulator
// no dependencies; used by fra_mul, fra_div and the core

package fra_pkg;

   localparam int FRAC_BITS_DEF = 28;
   localparam int WORD_W        = 32;
   localparam int ACC_W         = 64;
   localparam int QUOT_W        = 33;
   localparam int TOL_W         = 29;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ANN_ZERO = 2'd1;
   localparam logic [1:0] ST_DENOM    = 2'd2;
   localparam logic [1:0] ST_SAT      = 2'd3;

   typedef struct packed {
      logic             start;
      logic             full_frac;
      logic [ACC_W-1:0] numer;
      logic [ACC_W-1:0] denom;
   } fra_div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quot;
   } fra_div_rsp_type;

   typedef struct packed {
      logic                     sat;
      logic signed [WORD_W-1:0] val;
   } fra_clamp_type;

   typedef struct packed {
      logic                    ovf;
      logic signed [ACC_W-1:0] sum;
   } fra_sum_type;

   // signed 32-bit value from an unsigned quotient capped at 2^32
   function automatic fra_clamp_type fra_clamp(input logic [QUOT_W-1:0] q, input logic neg);
      fra_clamp_type r;
      r.sat = 1'b0;
      if (neg) begin
         if (q > QUOT_W'(64'h8000_0000)) begin
            r.sat = 1'b1;
            r.val = 32'sh8000_0000;
         end else begin
            r.val = $signed(32'd0 - q[WORD_W-1:0]);
         end
      end else begin
         if (q > QUOT_W'(64'h7FFF_FFFF)) begin
            r.sat = 1'b1;
            r.val = 32'sh7FFF_FFFF;
         end else begin
            r.val = $signed(q[WORD_W-1:0]);
         end
      end
      return r;
   endfunction

   function automatic fra_sum_type fra_sat_add(input logic signed [ACC_W-1:0] a,
                                               input logic signed [ACC_W-1:0] b);
      fra_sum_type r;
      logic signed [ACC_W-1:0] s;
      s = a + b;
      r.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
      if (r.ovf) begin
         r.sum = a[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         r.sum = s;
      end
      return r;
   endfunction

   function automatic logic [ACC_W-1:0] fra_mag(input logic signed [ACC_W-1:0] v);
      return v[ACC_W-1] ? (ACC_W'(0) - ACC_W'(v)) : ACC_W'(v);
   endfunction

endpackage

// ===== hw/rtl/fra_mul.sv =====
// registered 32 x 32 signed multiplier shared by all products of the core
// depends on fra_pkg

module fra_mul (
   input  logic                              clock,
   input  logic signed [fra_pkg::WORD_W-1:0] op_a,
   input  logic signed [fra_pkg::WORD_W-1:0] op_b,
   output logic signed [fra_pkg::ACC_W-1:0]  prod_ff
);
   import fra_pkg::*;

   logic signed [ACC_W-1:0] prod_in;

   assign prod_in = ACC_W'(op_a) * ACC_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== hw/rtl/fra_div.sv =====
// restoring divider, one quotient bit a cycle, quotient capped at 2^32
// computes floor(numer * 2^FRAC_BITS / denom) or floor(numer / denom); depends on fra_pkg

module fra_div #(
   parameter int FRAC_BITS = fra_pkg::FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fra_pkg::fra_div_req_type div_req,
   output fra_pkg::fra_div_rsp_type div_rsp
);
   import fra_pkg::*;

   localparam int NW = ACC_W + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]     num_ff, num_in;
   logic [ACC_W-1:0]  rem_ff, rem_in;
   logic [ACC_W-1:0]  den_ff, den_in;
   logic [QUOT_W-1:0] q_ff, q_in;
   logic              big_ff, big_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [ACC_W:0]    trial;
   logic              ge;
   logic              big_step;

   assign trial    = {rem_ff, num_ff[NW-1]};
   assign ge       = trial >= {1'b0, den_ff};
   // once the partial quotient reaches 2^32 it stops growing
   assign big_step = big_ff | q_ff[QUOT_W-1];

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      big_in  = big_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         num_in  = {div_req.numer, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = div_req.denom;
         q_in    = '0;
         big_in  = 1'b0;
         cnt_in  = div_req.full_frac ? CW'(NW) : CW'(ACC_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         rem_in = ge ? ACC_W'(trial - {1'b0, den_ff}) : trial[ACC_W-1:0];
         big_in = big_step;
         if (!big_step) begin
            q_in = {q_ff[QUOT_W-2:0], ge};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
      big_ff <= big_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = (big_ff || (q_ff > {1'b1, {(QUOT_W-1){1'b0}}}))
                         ? {1'b1, {(QUOT_W-1){1'b0}}} : q_ff;

endmodule

// ===== hw/rtl/fra_par_rate_accumulator_core.sv =====
// top level of the fra par rate accumulator: sequencer, sums and result register
// depends on fra_pkg, fra_mul and fra_div

// One word is one cashflow period. A period whose discount factor is above
// zero_tolerance uses three products on one registered multiplier and a
// 64-step division of df*tau by 1+tau*L. A skipped period, or one whose
// 1+tau*L is not positive, ends without the division. The word marked
// last_period adds the par rate division, which runs 64+FRAC_BITS steps on
// the same divider (92 at Q4.28). On top of that come the annuity test, the
// final quotient bit and the load of the output register. A zero annuity
// skips the division. The divider yields one quotient bit per cycle.
// req_stall is high from acceptance until the sequencer is back idle. A held
// result does not block the next word unless a new result is due.

module fra_par_rate_accumulator_core #(
   parameter int FRAC_BITS = fra_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [fra_pkg::TOL_W-1:0]         csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [fra_pkg::WORD_W-1:0] req_discount_factor,
   input  logic signed [fra_pkg::WORD_W-1:0] req_accrual_fraction,
   input  logic signed [fra_pkg::WORD_W-1:0] req_float_rate,
   input  logic                              req_last_period,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [fra_pkg::WORD_W-1:0] rsp_par_rate,
   output logic [1:0]                        rsp_status
);
   import fra_pkg::*;

   localparam logic signed [ACC_W-1:0] ONE  = ACC_W'(1) <<< FRAC_BITS;
   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_MUL_TR   = 12'b0000_0000_0010,
      S_DENOM    = 12'b0000_0000_0100,
      S_MUL_DT   = 12'b0000_0000_1000,
      S_GO_F     = 12'b0000_0001_0000,
      S_DIV_F    = 12'b0000_0010_0000,
      S_FACTOR   = 12'b0000_0100_0000,
      S_MUL_FR   = 12'b0000_1000_0000,
      S_ACC      = 12'b0001_0000_0000,
      S_FIN_TEST = 12'b0010_0000_0000,
      S_DIV_P    = 12'b0100_0000_0000,
      S_EMIT     = 12'b1000_0000_0000
   } fra_state_type;

   // round to nearest, ties up, dropping the fraction bits
   function automatic logic signed [ACC_W-1:0] shr_round(input logic signed [ACC_W-1:0] p);
      logic signed [ACC_W-1:0] s;
      s = p + HALF;
      return s >>> FRAC_BITS;
   endfunction

   fra_state_type             state_ff, state_in;
   logic [TOL_W-1:0]          tol_ff;
   logic signed [WORD_W-1:0]  df_ff, tau_ff, rate_ff, factor_ff, factor_in;
   logic                      last_ff;
   logic signed [ACC_W-1:0]   denom_ff, denom_in;
   logic signed [ACC_W-1:0]   rws_ff, rws_in, ann_ff, ann_in;
   logic [1:0]                sticky_ff, sticky_in;
   logic signed [WORD_W-1:0]  par_ff, par_in;
   logic [1:0]                status_ff, status_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [WORD_W-1:0]  rsp_par_ff, rsp_par_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic signed [WORD_W-1:0]  mul_a, mul_b;
   logic signed [ACC_W-1:0]   prod_ff;
   fra_div_req_type           div_req;
   fra_div_rsp_type           div_rsp;
   fra_clamp_type             fclamp, pclamp;
   fra_sum_type               rws_add, ann_add;
   logic [ACC_W-1:0]          ann_mag;
   logic                      df_counts;
   logic                      accept;
   logic                      out_free;

   fra_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod_ff)
   );

   fra_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign df_counts = df_ff > $signed({{(WORD_W-TOL_W){1'b0}}, tol_ff});
   assign ann_mag   = fra_mag(ann_ff);

   // df > 0 here, so the product sign follows tau
   assign fclamp  = fra_clamp(div_rsp.quot, tau_ff[WORD_W-1]);
   assign pclamp  = fra_clamp(div_rsp.quot, rws_ff[ACC_W-1] ^ ann_ff[ACC_W-1]);
   assign rws_add = fra_sat_add(rws_ff, shr_round(prod_ff));
   assign ann_add = fra_sat_add(ann_ff, ACC_W'(factor_ff));

   always_comb begin
      mul_a = factor_ff;
      mul_b = rate_ff;
      if (state_ff == S_MUL_TR) begin
         mul_a = tau_ff;
         mul_b = rate_ff;
      end else if (state_ff == S_MUL_DT) begin
         mul_a = df_ff;
         mul_b = tau_ff;
      end
   end

   always_comb begin
      div_req.start     = 1'b0;
      div_req.full_frac = 1'b0;
      div_req.numer     = fra_mag(prod_ff);
      div_req.denom     = ACC_W'(denom_ff);
      if (state_ff == S_GO_F) begin
         div_req.start = 1'b1;
      end else if (state_ff == S_FIN_TEST && ann_mag > ACC_W'(tol_ff)) begin
         div_req.start     = 1'b1;
         div_req.full_frac = 1'b1;
         div_req.numer     = fra_mag(rws_ff);
         div_req.denom     = ann_mag;
      end
   end

   always_comb begin
      state_in      = state_ff;
      denom_in      = denom_ff;
      factor_in     = factor_ff;
      rws_in        = rws_ff;
      ann_in        = ann_ff;
      sticky_in     = sticky_ff;
      par_in        = par_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_par_in    = rsp_par_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MUL_TR;
            end
         end
         S_MUL_TR: begin
            if (df_counts) begin
               state_in = S_DENOM;
            end else begin
               state_in = last_ff ? S_FIN_TEST : S_IDLE;
            end
         end
         S_DENOM: begin
            denom_in = ONE + shr_round(prod_ff);
            if (denom_in[ACC_W-1] || denom_in == '0) begin
               if (sticky_ff == ST_OK) begin
                  sticky_in = ST_DENOM;
               end
               state_in = last_ff ? S_FIN_TEST : S_IDLE;
            end else begin
               state_in = S_MUL_DT;
            end
         end
         S_MUL_DT: begin
            state_in = S_GO_F;
         end
         S_GO_F: begin
            state_in = S_DIV_F;
         end
         S_DIV_F: begin
            if (div_rsp.done) begin
               state_in = S_FACTOR;
            end
         end
         S_FACTOR: begin
            factor_in = fclamp.val;
            if (fclamp.sat && sticky_ff == ST_OK) begin
               sticky_in = ST_SAT;
            end
            state_in = S_MUL_FR;
         end
         S_MUL_FR: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            rws_in = rws_add.sum;
            ann_in = ann_add.sum;
            if ((rws_add.ovf || ann_add.ovf) && sticky_ff == ST_OK) begin
               sticky_in = ST_SAT;
            end
            state_in = last_ff ? S_FIN_TEST : S_IDLE;
         end
         S_FIN_TEST: begin
            if (ann_mag > ACC_W'(tol_ff)) begin
               state_in = S_DIV_P;
            end else begin
               par_in    = '0;
               status_in = ST_ANN_ZERO;
               state_in  = S_EMIT;
            end
         end
         S_DIV_P: begin
            if (div_rsp.done) begin
               par_in = pclamp.val;
               if (sticky_ff != ST_OK) begin
                  status_in = sticky_ff;
               end else begin
                  status_in = pclamp.sat ? ST_SAT : ST_OK;
               end
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_par_in    = par_ff;
               rsp_status_in = status_ff;
               rws_in        = '0;
               ann_in        = '0;
               sticky_in     = ST_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tol_ff       <= '0;
         rws_ff       <= '0;
         ann_ff       <= '0;
         sticky_ff    <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rws_ff       <= rws_in;
         ann_ff       <= ann_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tol_ff <= csr_wr_data;
         end
      end
      if (accept) begin
         df_ff   <= req_discount_factor;
         tau_ff  <= req_accrual_fraction;
         rate_ff <= req_float_rate;
         last_ff <= req_last_period;
      end
      denom_ff      <= denom_in;
      factor_ff     <= factor_in;
      par_ff        <= par_in;
      status_ff     <= status_in;
      rsp_par_ff    <= rsp_par_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_par_rate = rsp_par_ff;
   assign rsp_status   = rsp_status_ff;

endmodule
